### design/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared widths and payload types of the vector length clamp.
// ----------------------------------------------------------------------------
package vlc_pkg;

  localparam int COMP_W = 16;          // component width
  localparam int SUM_W  = 2 * COMP_W;  // squared magnitude
  localparam int U_W    = 3 * COMP_W;  // running q * s
  localparam int CAND_W = 4 * COMP_W;  // q * q * s and (a * m) squared
  localparam int NLANES = 3;

  typedef struct packed {
    logic signed [COMP_W-1:0] in_x;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic                     was_clamped;
  } out_t;

  // Working state of one component while its scaled magnitude is built.
  typedef struct packed {
    logic [COMP_W-1:0] v;      // original component bits
    logic [COMP_W-1:0] a;      // magnitude
    logic [COMP_W-1:0] q;      // result bits found so far
    logic [CAND_W-1:0] r;      // q * q * s
    logic [U_W-1:0]    u;      // q * s
    logic [SUM_W-1:0]  s;      // squared magnitude of the vector
    logic [CAND_W-1:0] p2;     // (a * max_length) squared
    logic              clamp;
  } lane_t;

  function automatic logic [COMP_W-1:0] magnitude(logic [COMP_W-1:0] v);
    return v[COMP_W-1] ? (~v + COMP_W'(1)) : v;
  endfunction

endpackage

### design/vlc_front.sv
// ----------------------------------------------------------------------------
// vlc_front
// Magnitudes, squares, squared length and clamp decision for the three lanes.
// ----------------------------------------------------------------------------
module vlc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ce_i,
  input  vlc_pkg::in_t                in_data_i,
  input  logic [vlc_pkg::COMP_W-1:0]  max_len_i,
  output vlc_pkg::lane_t              lane_o [vlc_pkg::NLANES]
);

  logic [vlc_pkg::COMP_W-1:0] v1_q   [vlc_pkg::NLANES];
  logic [vlc_pkg::COMP_W-1:0] a1_q   [vlc_pkg::NLANES];
  logic [vlc_pkg::COMP_W-1:0] v2_q   [vlc_pkg::NLANES];
  logic [vlc_pkg::COMP_W-1:0] a2_q   [vlc_pkg::NLANES];
  logic [vlc_pkg::SUM_W-1:0]  asq2_q [vlc_pkg::NLANES];
  logic [vlc_pkg::SUM_W-1:0]  p2_q   [vlc_pkg::NLANES];
  logic [vlc_pkg::SUM_W-1:0]  msq_q;
  logic [vlc_pkg::SUM_W-1:0]  s_d;
  logic [vlc_pkg::COMP_W-1:0] vin    [vlc_pkg::NLANES];

  assign vin[0] = in_data_i.in_x;
  assign vin[1] = in_data_i.in_y;
  assign vin[2] = in_data_i.in_z;

  assign s_d = asq2_q[0] + asq2_q[1] + asq2_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msq_q <= '0;
    end else begin
      msq_q <= vlc_pkg::SUM_W'(max_len_i) * vlc_pkg::SUM_W'(max_len_i);
    end
  end

  for (genvar i = 0; i < vlc_pkg::NLANES; i++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        v1_q[i]   <= vin[i];
        a1_q[i]   <= vlc_pkg::magnitude(vin[i]);
        v2_q[i]   <= v1_q[i];
        a2_q[i]   <= a1_q[i];
        asq2_q[i] <= vlc_pkg::SUM_W'(a1_q[i]) * vlc_pkg::SUM_W'(a1_q[i]);
        p2_q[i]   <= vlc_pkg::SUM_W'(a1_q[i]) * vlc_pkg::SUM_W'(max_len_i);
        lane_o[i].v     <= v2_q[i];
        lane_o[i].a     <= a2_q[i];
        lane_o[i].q     <= '0;
        lane_o[i].r     <= '0;
        lane_o[i].u     <= '0;
        lane_o[i].s     <= s_d;
        lane_o[i].p2    <= vlc_pkg::CAND_W'(p2_q[i]) * vlc_pkg::CAND_W'(p2_q[i]);
        lane_o[i].clamp <= s_d > msq_q;
      end
    end
  end

endmodule

### design/vlc_lane.sv
// ----------------------------------------------------------------------------
// vlc_lane
// One component: finds the scaled magnitude one bit per stage, MSB first.
// ----------------------------------------------------------------------------
module vlc_lane (
  input  logic            clk_i,
  input  logic            ce_i,
  input  vlc_pkg::lane_t  lane_i,
  output vlc_pkg::lane_t  lane_o
);

  vlc_pkg::lane_t st_q [vlc_pkg::COMP_W];
  vlc_pkg::lane_t st_d [vlc_pkg::COMP_W];

  for (genvar g = 0; g < vlc_pkg::COMP_W; g++) begin : g_stage
    localparam int B = vlc_pkg::COMP_W - 1 - g;
    vlc_pkg::lane_t            cur;
    logic [vlc_pkg::COMP_W-1:0] t;
    logic [vlc_pkg::CAND_W-1:0] cand;

    if (g == 0) begin : g_first
      assign cur = lane_i;
    end else begin : g_next
      assign cur = st_q[g-1];
    end

    // (q + 2^B)^2 * s = q*q*s + q*s*2^(B+1) + s*2^(2B)
    assign t    = cur.q | (vlc_pkg::COMP_W'(1) << B);
    assign cand = cur.r + (vlc_pkg::CAND_W'(cur.u) << (B + 1))
                + (vlc_pkg::CAND_W'(cur.s) << (2 * B));

    always_comb begin
      st_d[g] = cur;
      if (t <= cur.a && cand <= cur.p2) begin
        st_d[g].q = t;
        st_d[g].r = cand;
        st_d[g].u = cur.u + (vlc_pkg::U_W'(cur.s) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  assign lane_o = st_q[vlc_pkg::COMP_W-1];

endmodule

### design/vector_length_clamp_top.sv
// ----------------------------------------------------------------------------
// vector_length_clamp_top
// Limits the length of a signed three-component vector to max_length.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with in_data_i (x, y, z). Output
// channel: out_valid_o / out_stall_i with out_data_o (x, y, z, was_clamped).
// A transfer happens at a clock edge where valid is high and stall is low.
// Configuration: cfg_we_i writes cfg_wdata_i into max_length;
// write it only while no vector is in flight.
// The pipeline has one input stage, one multiply stage, one stage for the
// squared length and compare, sixteen stages of the per-component bit search
// (one result bit each), and the output register. Three lanes run side by
// side, so one vector is taken every cycle unless a stalled output result
// holds the pipeline.
// When the output is stalled while holding a result, the whole pipeline
// freezes and in_stall_o rises in the same cycle; it falls as soon as the
// result is taken. Reset empties the pipeline and sets max_length to all
// ones.
// ----------------------------------------------------------------------------
module vector_length_clamp_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  vlc_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output vlc_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [vlc_pkg::COMP_W-1:0]  cfg_wdata_i
);

  localparam int DEPTH = vlc_pkg::COMP_W + 3;

  logic                       ce;
  logic [vlc_pkg::COMP_W-1:0] max_len_q;
  logic [DEPTH-1:0]           vld_q;
  logic                       out_vld_q;
  vlc_pkg::out_t              out_q;
  vlc_pkg::out_t              out_d;
  vlc_pkg::lane_t             front [vlc_pkg::NLANES];
  vlc_pkg::lane_t             done  [vlc_pkg::NLANES];
  logic [vlc_pkg::COMP_W-1:0] res   [vlc_pkg::NLANES];

  assign ce         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '1;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  vlc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ce_i      (ce),
    .in_data_i (in_data_i),
    .max_len_i (max_len_q),
    .lane_o    (front)
  );

  for (genvar i = 0; i < vlc_pkg::NLANES; i++) begin : g_lane
    vlc_lane u_lane (
      .clk_i  (clk_i),
      .ce_i   (ce),
      .lane_i (front[i]),
      .lane_o (done[i])
    );
    assign res[i] = !done[i].clamp ? done[i].v :
                    done[i].v[vlc_pkg::COMP_W-1] ? (~done[i].q + vlc_pkg::COMP_W'(1))
                                                 : done[i].q;
  end

  // Merge the three lanes into one result.
  always_comb begin
    out_d.out_x       = res[0];
    out_d.out_y       = res[1];
    out_d.out_z       = res[2];
    out_d.was_clamped = done[0].clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (ce) begin
      vld_q     <= {vld_q[DEPTH-2:0], in_valid_i};
      out_vld_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A clamped result never holds the most negative value in any component.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_clamped |->
      out_data_o.out_x != {1'b1, {(vlc_pkg::COMP_W-1){1'b0}}} &&
      out_data_o.out_y != {1'b1, {(vlc_pkg::COMP_W-1){1'b0}}} &&
      out_data_o.out_z != {1'b1, {(vlc_pkg::COMP_W-1){1'b0}}})
    else $error("clamped result holds the most negative value");

  // The input side is only held back by a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

endmodule

### dv/tb_vector_length_clamp_top.sv
// ----------------------------------------------------------------------------
// tb_vector_length_clamp_top
// Directed and random test of the vector length clamp.
// ----------------------------------------------------------------------------
// Vectors are sent through the input channel with random gaps. The output
// side stalls at random. Every accepted vector is clamped by an exact
// integer predictor against the current max_length, and each output
// transfer is compared with the oldest predicted result. max_length is
// changed only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_vector_length_clamp_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 30;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  vlc_pkg::in_t               in_data_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  vlc_pkg::out_t              out_data_o;
  logic                       cfg_we_i = 1'b0;
  logic [vlc_pkg::COMP_W-1:0] cfg_wdata_i = '0;

  logic [vlc_pkg::COMP_W-1:0] cur_max = '1;
  vlc_pkg::out_t              clamped_q[$];
  int                         n_errors = 0;
  bit                         quiet = 1'b0;

  vector_length_clamp_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [vlc_pkg::COMP_W-1:0] abs_comp(logic [vlc_pkg::COMP_W-1:0] v);
    return v[vlc_pkg::COMP_W-1] ? (~v + vlc_pkg::COMP_W'(1)) : v;
  endfunction

  // Largest q <= a with q*q*s <= (a*m)^2, built one bit at a time.
  function automatic logic [vlc_pkg::COMP_W-1:0] shrink_mag(logic [vlc_pkg::COMP_W-1:0] a,
                                                             logic [vlc_pkg::COMP_W-1:0] m,
                                                             logic [63:0] s);
    logic [127:0] p2;
    logic [127:0] lhs;
    logic [vlc_pkg::COMP_W-1:0] q;
    logic [vlc_pkg::COMP_W-1:0] t;
    p2 = ({112'd0, a} * {112'd0, m}) * ({112'd0, a} * {112'd0, m});
    q = '0;
    for (int b = vlc_pkg::COMP_W - 1; b >= 0; b--) begin
      t = q | (vlc_pkg::COMP_W'(1) << b);
      lhs = {112'd0, t} * {112'd0, t} * {64'd0, s};
      if (t <= a && lhs <= p2) q = t;
    end
    return q;
  endfunction

  function automatic vlc_pkg::out_t clamp_vec(vlc_pkg::in_t d, logic [vlc_pkg::COMP_W-1:0] m);
    logic [vlc_pkg::COMP_W-1:0] v[3];
    logic [vlc_pkg::COMP_W-1:0] a[3];
    logic [vlc_pkg::COMP_W-1:0] q;
    logic [vlc_pkg::COMP_W-1:0] r[3];
    logic [63:0] s;
    logic clamp;
    vlc_pkg::out_t o;
    v[0] = d.in_x; v[1] = d.in_y; v[2] = d.in_z;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = abs_comp(v[i]);
      s += {48'd0, a[i]} * {48'd0, a[i]};
    end
    clamp = s > {48'd0, m} * {48'd0, m};
    for (int i = 0; i < 3; i++) begin
      if (clamp) begin
        q = shrink_mag(a[i], m, s);
        r[i] = v[i][vlc_pkg::COMP_W-1] ? (~q + vlc_pkg::COMP_W'(1)) : q;
      end else begin
        r[i] = v[i];
      end
    end
    o.out_x = r[0]; o.out_y = r[1]; o.out_z = r[2];
    o.was_clamped = clamp;
    return o;
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    case ($urandom_range(0, 19))
      0:       return $urandom_range(10, 40);
      1, 2, 3: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  // Output stall pattern: mostly short stalls, now and then a long one.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
      stall_left <= pick_gap();
    end
  end

  // Signals are stable at the falling edge; a transfer seen here happens at
  // the next rising edge.
  always @(negedge clk_i) begin
    vlc_pkg::out_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clamped_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        n_errors++;
      end else begin
        exp_o = clamped_q.pop_front();
        if (exp_o !== out_data_o) begin
          $display("%0t: expected %h actual %h", $time, exp_o, out_data_o);
          n_errors++;
        end
      end
    end
  end

  task automatic send_vec(vlc_pkg::in_t d);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    clamped_q.push_back(clamp_vec(d, cur_max));
  endtask

  task automatic set_max(logic [vlc_pkg::COMP_W-1:0] m);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (clamped_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_max = m;
  endtask

  function automatic vlc_pkg::in_t vec(int x, int y, int z);
    vlc_pkg::in_t d;
    d.in_x = vlc_pkg::COMP_W'(x);
    d.in_y = vlc_pkg::COMP_W'(y);
    d.in_z = vlc_pkg::COMP_W'(z);
    return d;
  endfunction

  function automatic vlc_pkg::in_t rand_vec();
    vlc_pkg::in_t d;
    int span;
    span = 1 << $urandom_range(1, 15);
    d.in_x = vlc_pkg::COMP_W'($urandom_range(0, 2 * span - 1) - span);
    d.in_y = vlc_pkg::COMP_W'($urandom_range(0, 2 * span - 1) - span);
    d.in_z = vlc_pkg::COMP_W'($urandom_range(0, 2 * span - 1) - span);
    if ($urandom_range(0, 3) == 0) begin
      d = vlc_pkg::in_t'((3 * vlc_pkg::COMP_W)'({$urandom(), $urandom()}));
    end
    if ($urandom_range(0, 3) == 0) d.in_z = vlc_pkg::COMP_W'($urandom());
    return d;
  endfunction

  task automatic test_reset_max();
    send_vec(vec(0, 0, 0));
    send_vec(vec(-32768, -32768, -32768));
    send_vec(vec(32767, 32767, 32767));
    send_vec(vec(-32768, 32767, 0));
  endtask

  task automatic test_zero_max();
    set_max(16'd0);
    send_vec(vec(0, 0, 0));
    send_vec(vec(1, 0, 0));
    send_vec(vec(-32768, -1, 32767));
  endtask

  task automatic test_unit_max();
    set_max(16'd256);
    send_vec(vec(256, 0, 0));
    send_vec(vec(257, 0, 0));
    send_vec(vec(-32768, 0, 0));
    send_vec(vec(-32768, -32768, -32768));
    send_vec(vec(32767, -32768, 1));
    send_vec(vec(100, -100, 100));
    set_max(16'd1);
    send_vec(vec(1, 0, 0));
    send_vec(vec(1, 1, 0));
    send_vec(vec(-1, -1, -1));
    set_max(16'd65535);
    send_vec(vec(-32768, -32768, -32768));
  endtask

  task automatic test_random();
    logic [vlc_pkg::COMP_W-1:0] m;
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 5)
        0:       m = '1;
        1:       m = '0;
        2:       m = vlc_pkg::COMP_W'($urandom_range(1, 255));
        default: m = vlc_pkg::COMP_W'($urandom());
      endcase
      set_max(m);
      quiet = (ph % 4 == 3);
      for (int i = 0; i < 100; i++) send_vec(rand_vec());
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_max();
    test_zero_max();
    test_unit_max();
    test_random();
    in_valid_i <= 1'b0;
    while (clamped_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
design/vlc_pkg.sv
design/vlc_front.sv
design/vlc_lane.sv
design/vector_length_clamp_top.sv
dv/tb_vector_length_clamp_top.sv
